/* rtl/assert_macros.svh */
// Assertion macros used by the checker file rst_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked on every rising clk edge outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* rtl/rst_pkg.sv */
// ----------------------------------------------------------------------------
// rst_pkg
// Shared types and constants of the randomized set table.
// ----------------------------------------------------------------------------
package rst_pkg;

  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int DrawW = 31;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [31:0] item_value;
    logic [DrawW-1:0]  random_draw;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] picked_value;
    logic [6:0]         member_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_READ_LAST,
    S_MOVE,
    S_DIV,
    S_PICK_RD,
    S_PICK_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic rd_last;
    logic wr_append;
    logic wr_move;
    logic div_start;
    logic div_step;
    logic rd_pick;
    logic take_pick;
    logic dec_count;
    logic inc_count;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       hit;
    logic       scan_end;
    logic       empty;
    logic       full;
    logic       slot_is_last;
    logic       div_done;
  } sts_t;

endpackage

/* rtl/randomized_set_table.sv */
// ----------------------------------------------------------------------------
// randomized_set_table
// Set of distinct 32-bit values with insert, remove and random pick.
// ----------------------------------------------------------------------------
// One word is handled at a time. Insert and remove scan the live slots one per
// cycle through the element memory read port; a remove that finds its value then
// reads the last member and moves it into the hole. Random pick runs a 31-step
// restoring modulo by the count and then reads the chosen slot. Work on an
// empty set skips the scan and the modulo. The result is held until taken.
module randomized_set_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rst_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rst_pkg::out_word_t out_data
);

  rst_pkg::cmd_t cmd;
  rst_pkg::sts_t sts;

  rst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rst_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .result  (out_data)
  );

endmodule

/* rtl/rst_datapath.sv */
// ----------------------------------------------------------------------------
// rst_datapath
// Element memory, occupancy, slot scan and serial modulo divider.
// ----------------------------------------------------------------------------
module rst_datapath (
  input  logic             clk,
  input  logic             rst,
  input  rst_pkg::in_word_t in_word,
  input  rst_pkg::cmd_t    cmd,
  output rst_pkg::sts_t    sts,
  output rst_pkg::out_word_t result
);

  logic [31:0] mem [rst_pkg::Capacity];
  logic [31:0] rd_data;
  logic [rst_pkg::IdxW-1:0] rd_addr;
  logic        rd_en;
  logic        wr_en;
  logic [rst_pkg::IdxW-1:0] wr_addr;
  logic [31:0] wr_data;

  logic [1:0]  action;
  logic [31:0] value;
  logic [rst_pkg::DrawW-1:0] draw;
  logic [rst_pkg::CntW-1:0] count;
  logic [rst_pkg::CntW-1:0] scan;
  logic [rst_pkg::IdxW-1:0] slot;
  logic [rst_pkg::IdxW-1:0] chk_idx;
  logic [31:0] picked;
  logic [rst_pkg::CntW-1:0] rem;
  logic [rst_pkg::CntW:0]   rem_sh;
  logic [4:0]  bit_idx;
  logic        div_done;
  logic [rst_pkg::CntW-1:0] last_idx;

  assign last_idx = count - rst_pkg::CntW'(1);

  always_comb begin
    rd_en = cmd.scan_start | cmd.scan_step | cmd.rd_last | cmd.rd_pick;
    if (cmd.rd_last) begin
      rd_addr = last_idx[rst_pkg::IdxW-1:0];
    end else if (cmd.rd_pick) begin
      rd_addr = rem[rst_pkg::IdxW-1:0];
    end else if (cmd.scan_start) begin
      rd_addr = '0;
    end else begin
      rd_addr = scan[rst_pkg::IdxW-1:0];
    end
    wr_en   = cmd.wr_append | cmd.wr_move;
    wr_addr = cmd.wr_append ? count[rst_pkg::IdxW-1:0] : slot;
    wr_data = cmd.wr_append ? value : rd_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rem_sh = {rem, draw[bit_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      div_done <= 1'b0;
    end else begin
      if (cmd.inc_count) begin
        count <= count + rst_pkg::CntW'(1);
      end else if (cmd.dec_count) begin
        count <= count - rst_pkg::CntW'(1);
      end
      if (cmd.div_start) begin
        div_done <= 1'b0;
      end else if (cmd.div_step && bit_idx == 5'd0) begin
        div_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= in_word.action;
      value  <= in_word.item_value;
      draw   <= in_word.random_draw;
      picked <= '0;
    end
    if (cmd.scan_start) begin
      scan    <= rst_pkg::CntW'(1);
      chk_idx <= '0;
    end else if (cmd.scan_step) begin
      scan    <= scan + rst_pkg::CntW'(1);
      chk_idx <= scan[rst_pkg::IdxW-1:0];
    end
    if (cmd.rd_last) begin
      slot <= chk_idx;
    end
    if (cmd.div_start) begin
      rem     <= '0;
      bit_idx <= 5'(rst_pkg::DrawW - 1);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, count}) begin
        rem <= rst_pkg::CntW'(rem_sh - {1'b0, count});
      end else begin
        rem <= rem_sh[rst_pkg::CntW-1:0];
      end
      bit_idx <= bit_idx - 5'd1;
    end
    if (cmd.take_pick) begin
      picked <= rd_data;
    end
  end

  always_comb begin
    sts.action       = action;
    sts.hit          = (rd_data == value);
    sts.scan_end     = ({1'b0, chk_idx} >= (count - rst_pkg::CntW'(1)));
    sts.empty        = (count == '0);
    sts.full         = (count == rst_pkg::CntW'(rst_pkg::Capacity));
    sts.slot_is_last = ({1'b0, slot} == last_idx);
    sts.div_done     = div_done;
    result.status       = cmd.status;
    result.picked_value = picked;
    result.member_count = 7'(count);
  end

endmodule

/* rtl/rst_ctrl.sv */
// ----------------------------------------------------------------------------
// rst_ctrl
// Sequencer for insert, remove and random pick.
// ----------------------------------------------------------------------------
module rst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rst_pkg::sts_t sts,
  output rst_pkg::cmd_t cmd
);

  rst_pkg::state_t state, state_next;
  logic [1:0] status, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rst_pkg::S_IDLE;
      status <= rst_pkg::ST_DONE;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    cmd.status  = status;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    unique case (state)
      rst_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rst_pkg::S_SCAN;
        end
      end
      rst_pkg::S_SCAN: begin
        priority if (sts.action == rst_pkg::ACT_PICK) begin
          if (sts.empty) begin
            status_next = rst_pkg::ST_EMPTY;
            state_next  = rst_pkg::S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = rst_pkg::S_DIV;
          end
        end else if (sts.action == rst_pkg::ACT_NONE || sts.empty) begin
          if (sts.action == rst_pkg::ACT_INSERT) begin
            cmd.wr_append = 1'b1;
            cmd.inc_count = 1'b1;
            status_next   = rst_pkg::ST_DONE;
          end else begin
            status_next = rst_pkg::ST_REJECT;
          end
          state_next = rst_pkg::S_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = rst_pkg::S_SCAN_CHK;
        end
      end
      rst_pkg::S_SCAN_CHK: begin
        if (sts.hit || sts.scan_end) begin
          priority if (sts.hit) begin
            if (sts.action == rst_pkg::ACT_INSERT) begin
              status_next = rst_pkg::ST_REJECT;
              state_next  = rst_pkg::S_OUT;
            end else begin
              status_next = rst_pkg::ST_DONE;
              cmd.rd_last = 1'b1;
              state_next  = rst_pkg::S_READ_LAST;
            end
          end else if (sts.action == rst_pkg::ACT_INSERT) begin
            if (sts.full) begin
              status_next = rst_pkg::ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
              cmd.inc_count = 1'b1;
              status_next   = rst_pkg::ST_DONE;
            end
            state_next = rst_pkg::S_OUT;
          end else begin
            status_next = rst_pkg::ST_REJECT;
            state_next  = rst_pkg::S_OUT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      rst_pkg::S_READ_LAST: begin
        state_next = rst_pkg::S_MOVE;
      end
      rst_pkg::S_MOVE: begin
        cmd.wr_move   = !sts.slot_is_last;
        cmd.dec_count = 1'b1;
        state_next    = rst_pkg::S_OUT;
      end
      rst_pkg::S_DIV: begin
        if (sts.div_done) begin
          cmd.rd_pick = 1'b1;
          state_next  = rst_pkg::S_PICK_RD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rst_pkg::S_PICK_RD: begin
        state_next = rst_pkg::S_PICK_WAIT;
      end
      rst_pkg::S_PICK_WAIT: begin
        cmd.take_pick = 1'b1;
        status_next   = rst_pkg::ST_DONE;
        state_next    = rst_pkg::S_OUT;
      end
      rst_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = rst_pkg::S_IDLE;
        end
      end
      default: state_next = rst_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/rst_checker.sv */
// ----------------------------------------------------------------------------
// rst_checker
// Port-level checks of the randomized set table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rst_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rst_pkg::out_word_t out_data
);

  `CHK_IMPLY(a_one_at_a_time, clk, rst, out_valid, in_stall)
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `CHK_IMPLY(a_pick_zero, clk, rst, out_valid && out_data.status != rst_pkg::ST_DONE, out_data.picked_value == 0)
  `CHK_IMPLY(a_count_max, clk, rst, out_valid, out_data.member_count <= 7'(rst_pkg::Capacity))

endmodule

bind randomized_set_table rst_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/tb_randomized_set_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_randomized_set_table
// Checks insert, remove and random pick of the randomized set table against
// a behavioral copy of the set, word by word, with random idling on both
// channels in some of the test phases.
// ----------------------------------------------------------------------------
module tb_randomized_set_table;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  rst_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  rst_pkg::out_word_t out_data;

  randomized_set_table uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  logic [31:0]        set_slots[rst_pkg::Capacity];
  int                 set_count;
  rst_pkg::out_word_t pending_results[$];
  int                 mismatches;
  int                 words_sent;
  int                 words_checked;
  int                 idle_pct;
  bit                 rx_idle_on;
  int                 pool[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  function automatic rst_pkg::out_word_t set_apply(rst_pkg::in_word_t w);
    rst_pkg::out_word_t r;
    int slot;
    slot = -1;
    r = '0;
    r.status = rst_pkg::ST_REJECT;
    if (w.action == rst_pkg::ACT_INSERT || w.action == rst_pkg::ACT_REMOVE) begin
      for (int i = 0; i < set_count; i++) begin
        if (slot < 0 && set_slots[i] == w.item_value) slot = i;
      end
    end
    case (w.action)
      rst_pkg::ACT_INSERT: begin
        if (slot >= 0) r.status = rst_pkg::ST_REJECT;
        else if (set_count >= rst_pkg::Capacity) r.status = rst_pkg::ST_FULL;
        else begin
          set_slots[set_count] = w.item_value;
          set_count++;
          r.status = rst_pkg::ST_DONE;
        end
      end
      rst_pkg::ACT_REMOVE: begin
        if (slot >= 0) begin
          set_slots[slot] = set_slots[set_count-1];
          set_count--;
          r.status = rst_pkg::ST_DONE;
        end
      end
      rst_pkg::ACT_PICK: begin
        if (set_count == 0) r.status = rst_pkg::ST_EMPTY;
        else begin
          r.picked_value = set_slots[w.random_draw % set_count];
          r.status = rst_pkg::ST_DONE;
        end
      end
      default: r.status = rst_pkg::ST_REJECT;
    endcase
    r.member_count = set_count[6:0];
    return r;
  endfunction

  task automatic send_word(logic [1:0] act, logic [31:0] val, logic [30:0] draw);
    rst_pkg::in_word_t w;
    w.action = act;
    w.item_value = val;
    w.random_draw = draw;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), set_apply(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int k;
    k = $urandom_range(9);
    if (k < 4 && pool.size() > 0) return pool[$urandom_range(pool.size() - 1)];
    if (k < 6) return $urandom_range(7);
    return $urandom;
  endfunction

  always @(posedge clk) begin
    rst_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_data);
      end else begin
        e = pending_results.pop_front();
        words_checked++;
        if (out_data.status !== e.status || out_data.picked_value !== e.picked_value ||
            out_data.member_count !== e.member_count) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= rx_idle_on && ($urandom_range(99) < 34);
  end

  task automatic test_directed();
    send_word(rst_pkg::ACT_PICK, 32'h0, 31'h7fffffff);
    send_word(rst_pkg::ACT_REMOVE, 32'h5, 31'h0);
    send_word(rst_pkg::ACT_INSERT, 32'h80000000, 31'h0);
    send_word(rst_pkg::ACT_INSERT, 32'h7fffffff, 31'h0);
    send_word(rst_pkg::ACT_INSERT, 32'hffffffff, 31'h0);
    send_word(rst_pkg::ACT_INSERT, 32'h0, 31'h0);
    send_word(rst_pkg::ACT_INSERT, 32'h7fffffff, 31'h0);
    send_word(rst_pkg::ACT_PICK, 32'h0, 31'h7fffffff);
    send_word(rst_pkg::ACT_PICK, 32'h0, 31'h0);
    send_word(rst_pkg::ACT_NONE, 32'h7fffffff, 31'h0);
    send_word(rst_pkg::ACT_REMOVE, 32'h80000000, 31'h0);
    send_word(rst_pkg::ACT_REMOVE, 32'h0, 31'h0);
    send_word(rst_pkg::ACT_REMOVE, 32'h0, 31'h0);
    send_word(rst_pkg::ACT_PICK, 32'h0, 31'h55555555);
    send_word(rst_pkg::ACT_REMOVE, 32'hffffffff, 31'h0);
    send_word(rst_pkg::ACT_REMOVE, 32'h7fffffff, 31'h0);
    send_word(rst_pkg::ACT_PICK, 32'hffffffff, 31'h2aaaaaaa);
  endtask

  task automatic test_fill_table();
    for (int i = 0; i < rst_pkg::Capacity; i++) begin
      send_word(rst_pkg::ACT_INSERT, 32'h1000 + i, 31'h0);
    end
    send_word(rst_pkg::ACT_INSERT, 32'hdeadbeef, 31'h0);
    send_word(rst_pkg::ACT_INSERT, 32'h1000, 31'h0);
    send_word(rst_pkg::ACT_PICK, 32'h0, 31'h7fffffff);
    send_word(rst_pkg::ACT_REMOVE, 32'h1000 + rst_pkg::Capacity - 1, 31'h0);
    send_word(rst_pkg::ACT_REMOVE, 32'h1000, 31'h0);
    for (int i = 1; i < rst_pkg::Capacity - 1; i++) begin
      send_word(rst_pkg::ACT_REMOVE, 32'h1000 + i, 31'h0);
    end
    send_word(rst_pkg::ACT_PICK, 32'h0, 31'h3);
  endtask

  task automatic test_random_mix(int n);
    logic [31:0] v;
    int k;
    for (int i = 0; i < n; i++) begin
      v = pick_value();
      k = $urandom_range(99);
      if (k < 45) begin
        send_word(rst_pkg::ACT_INSERT, v, 31'($urandom));
        pool.insert(pool.size(), v);
      end else if (k < 75) send_word(rst_pkg::ACT_REMOVE, v, 31'($urandom));
      else if (k < 97) send_word(rst_pkg::ACT_PICK, $urandom, 31'($urandom));
      else send_word(rst_pkg::ACT_NONE, v, 31'($urandom));
      if (pool.size() > 200) pool.delete(0);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rx_idle_on = 1'b0;
    idle_pct = 0;
    set_count = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    idle_pct = 34;
    rx_idle_on = 1'b1;
    test_fill_table();
    drain_results();
    test_random_mix(200);
    idle_pct = 0;
    rx_idle_on = 1'b0;
    test_random_mix(100);
    idle_pct = 34;
    rx_idle_on = 1'b1;
    test_random_mix(150);
    drain_results();
    $display("Sent %0d words (directed, full table, random mix); checked %0d results.",
             words_sent, words_checked);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* randomized_set_table.f */
+incdir+rtl
rtl/rst_pkg.sv
rtl/rst_datapath.sv
rtl/rst_ctrl.sv
rtl/randomized_set_table.sv
rtl/rst_checker.sv
test/tb_randomized_set_table.sv
